// File: rtl/core/b3blur_pkg.sv
// ----------------------------------------------------------------------------
// b3blur_pkg
// Shared types and constants for the binomial 3x3 blur: register map, input
// action codes and the control word passed from the front part to the back.
// ----------------------------------------------------------------------------
package b3blur_pkg;

    localparam int BLUR_W      = 20;   // result width, four fraction bits
    localparam int WIDTH_REG_W = 11;
    localparam int ROW_W       = 16;   // height register and row counter
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_LSB = 2;    // registers sit on 32-bit word addresses

    localparam int MIN_DIM            = 3;
    localparam int RESET_FRAME_WIDTH  = 1024;
    localparam int RESET_FRAME_HEIGHT = 1024;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } b3b_reg_idx_t;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_DRAIN = 1'b1
    } b3b_action_t;

    // Classification of one queued item
    typedef struct packed {
        logic drain;       // last-row drain rather than a pixel
        logic bank;        // pair-sum bank holding the row being formed
        logic col_first;   // pixel: column 0; drain: column 0
        logic col_second;  // pixel: column 1; drain: column 1
        logic col_last;    // column is the last of the row
        logic top_row;     // pixel in row 1, so results are for row 0
    } b3b_ctl_t;

endpackage

// File: rtl/core/b3blur_regs.sv
// ----------------------------------------------------------------------------
// b3blur_regs
// APB register file holding the frame size, plus the clamped last column and
// last row indexes used by the datapath.
// ----------------------------------------------------------------------------
module b3blur_regs #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [b3blur_pkg::APB_AW-1:0]       paddr,
    input  logic [b3blur_pkg::APB_DW-1:0]       pwdata,
    output logic [b3blur_pkg::APB_DW-1:0]       prdata,
    output logic                                pready,
    output logic [$clog2(MAX_WIDTH)-1:0]        last_col,
    output logic [b3blur_pkg::ROW_W-1:0]        last_row
);
    import b3blur_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int RST_W = (MAX_WIDTH < RESET_FRAME_WIDTH) ? MAX_WIDTH : RESET_FRAME_WIDTH;

    logic [WIDTH_REG_W-1:0] frame_width_reg, frame_width_next;
    logic [ROW_W-1:0]       frame_height_reg, frame_height_next;
    logic [AW-1:0]          last_col_reg, last_col_next;
    logic [ROW_W-1:0]       last_row_reg, last_row_next;
    logic                   wr_en;
    b3b_reg_idx_t           reg_idx;
    logic [31:0]            width_ext;
    logic [ROW_W-1:0]       height_val;

    assign reg_idx    = b3b_reg_idx_t'(paddr[REG_IDX_LSB]);
    assign wr_en      = psel && penable && pwrite;
    assign width_ext  = 32'(pwdata[WIDTH_REG_W-1:0]);
    assign height_val = pwdata[ROW_W-1:0];

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        last_col_next     = last_col_reg;
        last_row_next     = last_row_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH: begin
                    frame_width_next = pwdata[WIDTH_REG_W-1:0];
                    // clamp to the supported row length
                    if (width_ext < 32'(MIN_DIM)) begin
                        last_col_next = AW'(MIN_DIM - 1);
                    end else if (width_ext > 32'(MAX_WIDTH)) begin
                        last_col_next = AW'(MAX_WIDTH - 1);
                    end else begin
                        last_col_next = AW'(width_ext - 32'd1);
                    end
                end
                REG_FRAME_HEIGHT: begin
                    frame_height_next = height_val;
                    if (height_val < ROW_W'(MIN_DIM)) begin
                        last_row_next = ROW_W'(MIN_DIM - 1);
                    end else begin
                        last_row_next = height_val - ROW_W'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WIDTH_REG_W'(RESET_FRAME_WIDTH);
            frame_height_reg <= ROW_W'(RESET_FRAME_HEIGHT);
            last_col_reg     <= AW'(RST_W - 1);
            last_row_reg     <= ROW_W'(RESET_FRAME_HEIGHT - 1);
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            last_col_reg     <= last_col_next;
            last_row_reg     <= last_row_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_reg);
        endcase
    end

    assign pready   = 1'b1;
    assign last_col = last_col_reg;
    assign last_row = last_row_reg;

endmodule

// File: rtl/core/b3blur_front.sv
// ----------------------------------------------------------------------------
// b3blur_front
// Accepts input items, tracks the raster position and pending drains, keeps
// the previous-row sample line and hands classified items to the queue.
// ----------------------------------------------------------------------------
module b3blur_front #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_action,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample,
    input  logic [$clog2(MAX_WIDTH)-1:0]          last_col,
    input  logic [b3blur_pkg::ROW_W-1:0]          last_row,
    output logic                                  f_valid,
    input  logic                                  f_ready,
    output b3blur_pkg::b3b_ctl_t                  f_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]          f_col,
    output logic signed [SAMPLE_BITS-1:0]         f_sample,
    output logic signed [SAMPLE_BITS-1:0]         f_raw
);
    import b3blur_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [AW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             bank_reg, bank_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    dcol_reg, dcol_next;
    logic             fv_reg, fv_next;

    b3b_ctl_t                ctl_reg, ctl_next;
    logic [AW-1:0]           fcol_reg, fcol_next;
    logic signed [SAMPLE_BITS-1:0] fsamp_reg;
    logic signed [SAMPLE_BITS-1:0] raw_rd_reg;
    logic signed [SAMPLE_BITS-1:0] raw_mem [MAX_WIDTH];

    logic [AW-1:0]    x, c, raddr;
    logic [ROW_W-1:0] y;
    logic             is_drain, acc, keep, x_last, y_last, c_last;

    always_comb begin
        x        = (col_reg > last_col) ? last_col : col_reg;
        y        = (row_reg > last_row) ? last_row : row_reg;
        c        = (dcol_reg > last_col) ? last_col : dcol_reg;
        x_last   = (x == last_col);
        y_last   = (y == last_row);
        c_last   = (c == last_col);
        is_drain = (s_action == ACT_DRAIN);
        s_ready  = !fv_reg || f_ready;
        acc      = s_valid && s_ready;
        // row 0 pixels only fill the line; empty drains are dropped
        keep     = is_drain ? pend_reg : (y != '0);
        raddr    = is_drain ? c : x;

        col_next  = col_reg;
        row_next  = row_reg;
        bank_next = bank_reg;
        pend_next = pend_reg;
        dcol_next = dcol_reg;

        if (acc) begin
            if (is_drain) begin
                if (pend_reg) begin
                    if (c_last) begin
                        pend_next = 1'b0;
                    end else begin
                        dcol_next = c + AW'(1);
                    end
                end
            end else begin
                pend_next = 1'b0;
                if (x_last) begin
                    col_next = '0;
                    if (y != '0) begin
                        bank_next = ~bank_reg;
                    end
                    if (y_last) begin
                        row_next  = '0;
                        pend_next = 1'b1;
                        dcol_next = '0;
                    end else begin
                        row_next = y + ROW_W'(1);
                    end
                end else begin
                    col_next = x + AW'(1);
                end
            end
        end

        fv_next = acc ? keep : (fv_reg && !f_ready);

        ctl_next.drain      = is_drain;
        ctl_next.bank       = bank_reg;
        ctl_next.col_first  = is_drain ? (c == '0) : (x == '0);
        ctl_next.col_second = is_drain ? (c == AW'(1)) : (x == AW'(1));
        ctl_next.col_last   = is_drain ? c_last : x_last;
        ctl_next.top_row    = (y == ROW_W'(1));
        // pixel reads the pair-sum line one column behind
        fcol_next           = is_drain ? c : (x - AW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            bank_reg <= 1'b0;
            pend_reg <= 1'b0;
            dcol_reg <= '0;
            fv_reg   <= 1'b0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            bank_reg <= bank_next;
            pend_reg <= pend_next;
            dcol_reg <= dcol_next;
            fv_reg   <= fv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            ctl_reg   <= ctl_next;
            fcol_reg  <= fcol_next;
            fsamp_reg <= s_sample;
        end
    end

    // sample line: read the sample above before it is overwritten
    always_ff @(posedge aclk) begin
        if (acc) begin
            raw_rd_reg <= raw_mem[raddr];
            if (!is_drain) begin
                raw_mem[x] <= s_sample;
            end
        end
    end

    assign f_valid  = fv_reg;
    assign f_ctl    = ctl_reg;
    assign f_col    = fcol_reg;
    assign f_sample = fsamp_reg;
    assign f_raw    = raw_rd_reg;

endmodule

// File: rtl/core/b3blur_queue.sv
// ----------------------------------------------------------------------------
// b3blur_queue
// Two-entry FIFO between the front and back parts so each can stall alone.
// ----------------------------------------------------------------------------
module b3blur_queue #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);
    localparam int DEPTH = 2;
    localparam int CNT_W = 2;

    logic [DW-1:0]    slot_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    always_comb begin
        in_ready    = (count_reg != CNT_W'(DEPTH));
        out_valid   = (count_reg != '0);
        push        = in_valid && in_ready;
        pop         = out_valid && out_ready;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    assign out_data = slot_reg[rd_ptr_reg];

endmodule

// File: rtl/core/b3blur_back.sv
// ----------------------------------------------------------------------------
// b3blur_back
// Forms the 2x2 pair sums, keeps the two pair-sum lines and produces blurred
// results: one per pixel past column 0, two for a row's last, one per drain.
// ----------------------------------------------------------------------------
module b3blur_back #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   q_valid,
    output logic                                   q_ready,
    input  b3blur_pkg::b3b_ctl_t                   q_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]           q_col,
    input  logic signed [SAMPLE_BITS-1:0]          q_sample,
    input  logic signed [SAMPLE_BITS-1:0]          q_raw,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [b3blur_pkg::BLUR_W-1:0]   m_blurred,
    output logic                                   m_run_last,
    output logic                                   m_frame_last
);
    import b3blur_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int TW = SAMPLE_BITS + 2;   // pair sum
    localparam int RW = SAMPLE_BITS + 4;   // result before width fit

    logic          b1_valid_reg, b1_valid_next;
    logic          phase_reg, phase_next;
    logic          out_valid_reg, out_valid_next;

    b3b_ctl_t                      ctl_reg;
    logic [AW-1:0]                 col_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] raw_reg;
    logic signed [TW-1:0]          tmem_rd_reg;

    logic signed [SAMPLE_BITS-1:0] raw_hold_reg;
    logic signed [SAMPLE_BITS-1:0] prev_sample_reg;
    logic signed [TW-1:0]          prev_hold_reg;
    logic signed [TW-1:0]          t_left_reg;
    logic signed [TW-1:0]          prev_t_last_reg;

    logic signed [BLUR_W-1:0]      blurred_reg, blurred_next;
    logic                          run_last_reg, run_last_next;
    logic                          frame_last_reg, frame_last_next;

    logic signed [TW-1:0] tmem [2][MAX_WIDTH];

    logic                 out_free, has_res, two, emit, done, adv, pop, t_wr;
    logic signed [TW-1:0] t_cur, t_last, pc;
    logic signed [RW-1:0] rv0, rv1, rvd, tc, tl, r_sel;

    // pair sums and candidate results
    always_comb begin
        t_cur = TW'(raw_hold_reg) + TW'(raw_reg) + TW'(prev_sample_reg) + TW'(sample_reg);
        t_last = ctl_reg.top_row ? TW'(raw_reg) : (TW'(raw_reg) <<< 2);

        if (ctl_reg.top_row || ctl_reg.col_second) begin
            rv0 = RW'(t_cur) <<< 2;
        end else begin
            rv0 = RW'(t_cur) + RW'(t_left_reg) + RW'(tmem_rd_reg) + RW'(prev_hold_reg);
        end

        if (ctl_reg.top_row) begin
            rv1 = RW'(raw_reg) <<< 4;
        end else begin
            rv1 = RW'(t_last) + RW'(t_cur) + RW'(prev_t_last_reg) + RW'(tmem_rd_reg);
        end

        // last row: its own pair sums are scaled samples
        tc = ctl_reg.col_last ? RW'(raw_reg) : (RW'(raw_reg) <<< 2);
        tl = ctl_reg.col_second ? RW'(raw_hold_reg) : (RW'(raw_hold_reg) <<< 2);
        pc = ctl_reg.col_last ? prev_t_last_reg : tmem_rd_reg;
        if (ctl_reg.col_first) begin
            rvd = RW'(raw_reg) <<< 4;
        end else begin
            rvd = tc + tl + RW'(pc) + RW'(prev_hold_reg);
        end

        r_sel = ctl_reg.drain ? rvd : (phase_reg ? rv1 : rv0);
    end

    // item sequencing and output register
    always_comb begin
        out_free = !out_valid_reg || m_ready;
        has_res  = ctl_reg.drain || !ctl_reg.col_first;
        two      = !ctl_reg.drain && ctl_reg.col_last;
        emit     = b1_valid_reg && has_res && out_free;
        done     = b1_valid_reg && (!has_res || (out_free && (!two || phase_reg)));
        adv      = !b1_valid_reg || done;
        q_ready  = adv;
        pop      = adv && q_valid;
        t_wr     = done && !ctl_reg.drain && !ctl_reg.col_first;

        b1_valid_next = adv ? q_valid : b1_valid_reg;
        if (done) begin
            phase_next = 1'b0;
        end else if (emit) begin
            phase_next = 1'b1;
        end else begin
            phase_next = phase_reg;
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        blurred_next    = emit ? BLUR_W'(r_sel) : blurred_reg;
        run_last_next   = emit ? (!two || phase_reg) : run_last_reg;
        frame_last_next = emit ? (ctl_reg.drain && ctl_reg.col_last) : frame_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            b1_valid_reg  <= b1_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        blurred_reg    <= blurred_next;
        run_last_reg   <= run_last_next;
        frame_last_reg <= frame_last_next;
        if (pop) begin
            ctl_reg    <= q_ctl;
            col_reg    <= q_col;
            sample_reg <= q_sample;
            raw_reg    <= q_raw;
        end
        // advance the neighbour windows once per retired item
        if (done) begin
            raw_hold_reg  <= raw_reg;
            prev_hold_reg <= tmem_rd_reg;
            if (!ctl_reg.drain) begin
                t_left_reg      <= t_cur;
                prev_sample_reg <= sample_reg;
                if (ctl_reg.col_last) begin
                    prev_t_last_reg <= t_last;
                end
            end
        end
    end

    // pair-sum lines: read the finished row, write the one being formed
    always_ff @(posedge aclk) begin
        if (pop) begin
            tmem_rd_reg <= tmem[~q_ctl.bank][q_col];
        end
        if (t_wr) begin
            tmem[ctl_reg.bank][col_reg] <= t_cur;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_blurred    = blurred_reg;
    assign m_run_last   = run_last_reg;
    assign m_frame_last = frame_last_reg;

endmodule

// File: rtl/core/binomial_3x3_image_blur.sv
// ----------------------------------------------------------------------------
// binomial_3x3_image_blur
// Binomial 3x3 blur of a raster stream built from two 2x2 box passes, with
// line buffers; results are scaled by 16 and follow one row behind.
//
// Channel | Ports                                            | Transfer when
// s_      | s_valid s_ready s_action s_sample                | s_valid & s_ready
// m_      | m_valid m_ready m_blurred m_run_last m_frame_last | m_valid & m_ready
// APB     | psel penable pwrite paddr pwdata prdata pready   | psel & penable
//
// One input item per clock while s_ready is high; each item passes the front
// register, the queue and the back item register, and its result the output
// register. The last pixel of a row gives two results through the single
// output register; drains give one result per cycle while m_ready is high.
// While m_ready is low the two-entry queue takes front items until it is full.
// Reset is synchronous on aresetn; line buffers are not cleared and need none.
// ----------------------------------------------------------------------------
module binomial_3x3_image_blur #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_action,
    input  logic signed [SAMPLE_BITS-1:0]          s_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [b3blur_pkg::BLUR_W-1:0]   m_blurred,
    output logic                                   m_run_last,
    output logic                                   m_frame_last,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [b3blur_pkg::APB_AW-1:0]          paddr,
    input  logic [b3blur_pkg::APB_DW-1:0]          pwdata,
    output logic [b3blur_pkg::APB_DW-1:0]          prdata,
    output logic                                   pready
);
    import b3blur_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CTL_W = $bits(b3b_ctl_t);
    localparam int QW    = CTL_W + AW + 2 * SAMPLE_BITS;

    logic [AW-1:0]    last_col;
    logic [ROW_W-1:0] last_row;

    logic                          f_valid, f_ready;
    b3b_ctl_t                      f_ctl;
    logic [AW-1:0]                 f_col;
    logic signed [SAMPLE_BITS-1:0] f_sample, f_raw;

    logic                          q_valid, q_ready;
    logic [QW-1:0]                 q_data;
    b3b_ctl_t                      q_ctl;
    logic [AW-1:0]                 q_col;
    logic signed [SAMPLE_BITS-1:0] q_sample, q_raw;

    b3blur_regs #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .last_col (last_col),
        .last_row (last_row)
    );

    b3blur_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .s_sample (s_sample),
        .last_col (last_col),
        .last_row (last_row),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_ctl    (f_ctl),
        .f_col    (f_col),
        .f_sample (f_sample),
        .f_raw    (f_raw)
    );

    b3blur_queue #(
        .DW (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_ctl, f_col, f_sample, f_raw}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    assign {q_ctl, q_col, q_sample, q_raw} = q_data;

    b3blur_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_ctl        (q_ctl),
        .q_col        (q_col),
        .q_sample     (q_sample),
        .q_raw        (q_raw),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_blurred    (m_blurred),
        .m_run_last   (m_run_last),
        .m_frame_last (m_frame_last)
    );

endmodule
